>>> hw/rtl/rmsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsm_pkg
// Types, constants and helpers shared by the block RMS level meter.
// ----------------------------------------------------------------------------
package rmsm_pkg;

    localparam int NUM_CH    = 8;
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = SAMPLE_W + $clog2(NUM_CH);
    localparam int SQ_W      = 2 * SUM_W - 1;
    localparam int TIME_W    = 48;
    localparam int DUR_W     = 10;
    localparam int LEVEL_W   = 20;
    localparam int CH_W      = 4;
    localparam int RATE_W    = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 18;

    localparam int DEF_MAX_BLOCK_FRAMES = 4096;
    localparam int DEF_MAX_GAPS         = 63;

    localparam int MS_PER_S     = 1000;
    localparam int MS_W         = 10;
    localparam int FULL_SCALE   = 32767;
    localparam int ROOT_SHIFT   = 20;
    localparam int LEVEL_SHIFT  = 6;
    // smallest root whose scaled level no longer fits in LEVEL_W bits
    localparam logic [63:0] LVL_SAT_ROOT = 64'd536854528;

    localparam logic [DUR_W-1:0]   DUR_MAX   = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    localparam logic              ENABLE_RST = 1'b0;
    localparam logic [RATE_W-1:0] RATE_RST   = 18'd48000;
    localparam logic [CH_W-1:0]   CHAN_RST   = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE        = 2'd0,
        REG_SAMPLE_RATE   = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_ch0;
        logic signed [SAMPLE_W-1:0] sample_ch1;
        logic signed [SAMPLE_W-1:0] sample_ch2;
        logic signed [SAMPLE_W-1:0] sample_ch3;
        logic signed [SAMPLE_W-1:0] sample_ch4;
        logic signed [SAMPLE_W-1:0] sample_ch5;
        logic signed [SAMPLE_W-1:0] sample_ch6;
        logic signed [SAMPLE_W-1:0] sample_ch7;
        logic                       last_frame;
        logic [TIME_W-1:0]          block_time_ms;
    } frame_t;

    typedef struct packed {
        logic [TIME_W-1:0]  record_time_ms;
        logic [DUR_W-1:0]   duration_ms;
        logic [LEVEL_W-1:0] level;
        logic [CH_W-1:0]    channels_used;
        logic               format_changed;
        logic               is_gap;
        logic               last_result;
    } record_t;

    typedef struct packed {
        logic              enable;
        logic [RATE_W-1:0] sample_rate;
        logic [CH_W-1:0]   channels;
    } cfg_t;

    function automatic logic [CH_W-1:0] eff_channels(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        if (c == '0)
            r = CH_W'(1);
        else if (c > CH_W'(NUM_CH))
            r = CH_W'(NUM_CH);
        else
            r = c;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/audio_block_rms_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_block_rms_meter
// Block RMS level meter: accumulates mono power per block, emits level records.
// ----------------------------------------------------------------------------
//  channel   | handshake            | word
//  ----------+----------------------+-------------------------------
//  frames    | push / full          | frame_t  (8 samples, last, time)
//  records   | pop / empty          | record_t (time, duration, level)
//  config    | wr_en, wr_index      | wr_data  (18 bits)
//
//  A frame passes through the mix, square and accumulate stages of the front end.
//  A measured block end runs the divider for the duration, then for the mean,
//  then the root unit, scales the level unless the root saturates, and then
//  writes one word per gap and one for the record.
//  Two block jobs queue between front and back; records leave via a 2-word queue.
//  Reset is asynchronous and clears config to its defaults and the control state.
// ----------------------------------------------------------------------------
module audio_block_rms_meter
    import rmsm_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = DEF_MAX_BLOCK_FRAMES,
    parameter int MAX_GAPS         = DEF_MAX_GAPS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire frame_t               frame,
    output logic                      empty,
    input  wire logic                 pop,
    output record_t                   record,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0]     wr_data
);

    localparam int FR_W  = $clog2(MAX_BLOCK_FRAMES + 1);
    localparam int ACC_W = SQ_W + FR_W;

    logic              enable_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [CH_W-1:0]   chan_reg;
    logic              cfg_change;
    cfg_t              cfg;

    logic              job_valid;
    logic              job_take;
    logic [FR_W-1:0]   job_frames;
    logic [ACC_W-1:0]  job_acc;
    logic [TIME_W-1:0] job_time;
    logic              job_measure;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= ENABLE_RST;
            rate_reg   <= RATE_RST;
            chan_reg   <= CHAN_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ENABLE:        enable_reg <= wr_data[0];
                REG_SAMPLE_RATE:   rate_reg   <= wr_data[RATE_W-1:0];
                REG_CHANNEL_COUNT: chan_reg   <= wr_data[CH_W-1:0];
                default:           ;
            endcase
        end
    end

    // a format write that changes the value restarts the time line
    assign cfg_change = wr_en &&
        ((wr_index == REG_SAMPLE_RATE && wr_data[RATE_W-1:0] != rate_reg) ||
         (wr_index == REG_CHANNEL_COUNT && wr_data[CH_W-1:0] != chan_reg));

    assign cfg.enable      = enable_reg;
    assign cfg.sample_rate = rate_reg;
    assign cfg.channels    = eff_channels(chan_reg);

    rmsm_front #(.MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .frame       (frame),
        .cfg         (cfg),
        .job_valid   (job_valid),
        .job_take    (job_take),
        .job_frames  (job_frames),
        .job_acc     (job_acc),
        .job_time    (job_time),
        .job_measure (job_measure)
    );

    rmsm_back #(
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES),
        .MAX_GAPS         (MAX_GAPS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cfg_change  (cfg_change),
        .job_valid   (job_valid),
        .job_take    (job_take),
        .job_frames  (job_frames),
        .job_acc     (job_acc),
        .job_time    (job_time),
        .job_measure (job_measure),
        .empty       (empty),
        .pop         (pop),
        .record      (record)
    );

endmodule
`default_nettype wire

>>> hw/rtl/rmsm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsm_div
// Restoring divider, one quotient bit per cycle. Divide by zero gives all ones.
// ----------------------------------------------------------------------------
module rmsm_div #(
    parameter int DW = 49,
    parameter int VW = 18
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    q_reg;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [VW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, q_reg[DW-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? VW'(trial - {1'b0, d_reg}) : trial[VW-1:0];
            q_reg   <= {q_reg[DW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

>>> hw/rtl/rmsm_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsm_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rmsm_sqrt #(
    parameter int RW = 35
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [2*RW-1:0] radicand,
    output logic                 done,
    output logic [RW-1:0]        root
);

    localparam int CNT_W = $clog2(RW + 1);

    logic [2*RW-1:0]  rad_reg;
    logic [RW:0]      rem_reg;
    logic [RW-1:0]    root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RW+2:0]    rem_sh;
    logic [RW+2:0]    trial;
    logic             fits;

    assign rem_sh = {rem_reg, rad_reg[2*RW-1:2*RW-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*RW-3:0], 2'b00};
            rem_reg  <= fits ? (RW+1)'(rem_sh - trial) : rem_sh[RW:0];
            root_reg <= {root_reg[RW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

>>> hw/rtl/rmsm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsm_front
// Takes frames, mixes to mono, squares and accumulates; queues one job per block.
// ----------------------------------------------------------------------------
module rmsm_front
    import rmsm_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = DEF_MAX_BLOCK_FRAMES,
    localparam int FR_W  = $clog2(MAX_BLOCK_FRAMES + 1),
    localparam int ACC_W = SQ_W + FR_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire frame_t            frame,
    input  wire cfg_t              cfg,
    output logic                   job_valid,
    input  wire logic              job_take,
    output logic [FR_W-1:0]        job_frames,
    output logic [ACC_W-1:0]       job_acc,
    output logic [TIME_W-1:0]      job_time,
    output logic                   job_measure
);

    localparam int QD = 2;

    logic signed [SAMPLE_W-1:0] samples [NUM_CH];
    logic signed [SUM_W-1:0]    sum;
    logic                       counted;
    logic                       accept;

    logic                    s1_valid_reg, s2_valid_reg;
    logic signed [SUM_W-1:0] s1_sum_reg;
    logic                    s1_last_reg, s2_last_reg;
    logic                    s1_meas_reg, s2_meas_reg;
    logic [TIME_W-1:0]       s1_time_reg, s2_time_reg;
    logic [FR_W-1:0]         s1_frames_reg, s2_frames_reg;
    logic [SQ_W-1:0]         s2_sq_reg;
    logic signed [2*SUM_W-1:0] sq_full;
    logic [FR_W-1:0]         cnt_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_total;

    logic [FR_W-1:0]   q_frames [QD];
    logic [ACC_W-1:0]  q_acc    [QD];
    logic [TIME_W-1:0] q_time   [QD];
    logic              q_meas   [QD];
    logic              q_wr_reg, q_rd_reg;
    logic [1:0]        q_cnt_reg;
    logic              q_push;

    assign samples[0] = frame.sample_ch0;
    assign samples[1] = frame.sample_ch1;
    assign samples[2] = frame.sample_ch2;
    assign samples[3] = frame.sample_ch3;
    assign samples[4] = frame.sample_ch4;
    assign samples[5] = frame.sample_ch5;
    assign samples[6] = frame.sample_ch6;
    assign samples[7] = frame.sample_ch7;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (CH_W'(i) < cfg.channels)
                sum = sum + SUM_W'(samples[i]);
        end
    end

    // one frame in flight at most and none while the queue is full, so the queue never overflows
    assign full    = s1_valid_reg | s2_valid_reg | (q_cnt_reg == 2'(QD));
    assign accept  = push & ~full;
    assign counted = cfg.enable & (cnt_reg < FR_W'(MAX_BLOCK_FRAMES));

    assign sq_full   = s1_sum_reg * s1_sum_reg;
    assign acc_total = acc_reg + ACC_W'(s2_sq_reg);
    assign q_push    = s2_valid_reg & s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            acc_reg      <= '0;
            q_wr_reg     <= 1'b0;
            q_rd_reg     <= 1'b0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (accept)
            begin
                if (frame.last_frame)
                    cnt_reg <= '0;
                else if (counted)
                    cnt_reg <= cnt_reg + FR_W'(1);
            end
            if (s2_valid_reg)
                acc_reg <= s2_last_reg ? '0 : acc_total;
            if (q_push)
                q_wr_reg <= ~q_wr_reg;
            if (job_take)
                q_rd_reg <= ~q_rd_reg;
            q_cnt_reg <= q_cnt_reg + 2'(q_push) - 2'(job_take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sum_reg    <= counted ? sum : '0;
            s1_last_reg   <= frame.last_frame;
            s1_meas_reg   <= cfg.enable;
            s1_time_reg   <= frame.block_time_ms;
            s1_frames_reg <= counted ? cnt_reg + FR_W'(1) : cnt_reg;
        end
        s2_sq_reg     <= SQ_W'(sq_full);
        s2_last_reg   <= s1_last_reg;
        s2_meas_reg   <= s1_meas_reg;
        s2_time_reg   <= s1_time_reg;
        s2_frames_reg <= s1_frames_reg;
        if (q_push)
        begin
            q_frames[q_wr_reg] <= s2_frames_reg;
            q_acc[q_wr_reg]    <= acc_total;
            q_time[q_wr_reg]   <= s2_time_reg;
            q_meas[q_wr_reg]   <= s2_meas_reg;
        end
    end

    assign job_valid   = q_cnt_reg != '0;
    assign job_frames  = q_frames[q_rd_reg];
    assign job_acc     = q_acc[q_rd_reg];
    assign job_time    = q_time[q_rd_reg];
    assign job_measure = q_meas[q_rd_reg];

endmodule
`default_nettype wire

>>> hw/rtl/rmsm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsm_back
// Finishes a measured block: duration, mean, root, level, gap words, then the record.
// ----------------------------------------------------------------------------
module rmsm_back
    import rmsm_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = DEF_MAX_BLOCK_FRAMES,
    parameter int MAX_GAPS         = DEF_MAX_GAPS,
    localparam int FR_W  = $clog2(MAX_BLOCK_FRAMES + 1),
    localparam int ACC_W = SQ_W + FR_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              cfg_change,
    input  wire logic              job_valid,
    output logic                   job_take,
    input  wire logic [FR_W-1:0]   job_frames,
    input  wire logic [ACC_W-1:0]  job_acc,
    input  wire logic [TIME_W-1:0] job_time,
    input  wire logic              job_measure,
    output logic                   empty,
    input  wire logic              pop,
    output record_t                record
);

    localparam int RT_W = (ACC_W + ROOT_SHIFT + 1) / 2;
    localparam int GC_W = $clog2(MAX_GAPS + 1);
    localparam int OD   = 2;
    // full scale is 2^FS_W - 1; an unsaturated root * 64 stays below 2^LX_W
    localparam int FS_W = 15;
    localparam int LX_W = 36;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DUR  = 7'b0000010,
        ST_MEAN = 7'b0000100,
        ST_ROOT = 7'b0001000,
        ST_LVL  = 7'b0010000,
        ST_GAP  = 7'b0100000,
        ST_MEAS = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [TIME_W-1:0]  last_time_reg;
    logic               change_pending_reg;
    logic [TIME_W-1:0]  t_reg;
    logic [FR_W-1:0]    frames_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [TIME_W:0]    next_reg;
    logic               gap_on_reg;
    logic [GC_W-1:0]    gap_cnt_reg;
    logic [LX_W-1:0]    lv_x_reg;
    logic [LEVEL_W-1:0] lv_q_reg;

    logic               div_start;
    logic [ACC_W-1:0]   div_dividend;
    logic [RATE_W-1:0]  div_divisor;
    logic               div_done;
    logic [ACC_W-1:0]   div_q;
    logic               sq_start;
    logic [2*RT_W-1:0]  sq_radicand;
    logic               sq_done;
    logic [RT_W-1:0]    sq_root;

    logic [FR_W+MS_W-1:0] frames_ms;
    logic [DUR_W-1:0]     dur_sat;
    logic [TIME_W-1:0]    lt_eff;
    logic [ACC_W-1:0]     mean;
    logic                 root_sat;
    logic                 gap_more;
    logic [LX_W-FS_W-1:0] lv_hi;
    logic [FS_W-1:0]      lv_lo;

    record_t              of_mem [OD];
    logic                 of_wr_reg, of_rd_reg;
    logic [1:0]           of_cnt_reg;
    logic                 of_full;
    logic                 of_push;
    logic                 of_pop;
    record_t              of_word;

    rmsm_div #(.DW(ACC_W), .VW(RATE_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    rmsm_sqrt #(.RW(RT_W)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_radicand),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign frames_ms = (FR_W+MS_W)'(job_frames) * (FR_W+MS_W)'(MS_PER_S);
    // a zero rate divides to all ones, which saturates like a long block
    assign dur_sat   = (div_q > ACC_W'(DUR_MAX)) ? DUR_MAX : div_q[DUR_W-1:0];
    assign lt_eff    = (t_reg < last_time_reg) ? '0 : last_time_reg;
    assign mean      = (frames_reg == '0) ? '0 : div_q;
    assign root_sat  = 64'(sq_root) >= LVL_SAT_ROOT;
    assign gap_more  = gap_on_reg && (next_reg < {1'b0, t_reg})
                       && (gap_cnt_reg < GC_W'(MAX_GAPS));
    assign of_full   = of_cnt_reg == 2'(OD);
    assign job_take  = (state_reg == ST_IDLE) & job_valid;
    // fold the high part onto the low part: x = hi*2^15 + lo = hi*(2^15-1) + hi + lo
    assign lv_hi     = lv_x_reg[LX_W-1:FS_W];
    assign lv_lo     = lv_x_reg[FS_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = ACC_W'(frames_ms);
        div_divisor  = cfg.sample_rate;
        sq_start     = 1'b0;
        sq_radicand  = (2*RT_W)'({mean, ROOT_SHIFT'(0)});
        of_push      = 1'b0;
        of_word      = '0;
        of_word.duration_ms   = dur_reg;
        of_word.channels_used = cfg.channels;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && job_measure)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DUR;
                end
            end
            ST_DUR:
            begin
                if (div_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = acc_reg;
                    div_divisor  = RATE_W'(frames_reg);
                    state_next   = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    sq_start   = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sq_done)
                begin
                    if (root_sat)
                        state_next = ST_GAP;
                    else
                        state_next = ST_LVL;
                end
            end
            ST_LVL:
            begin
                if (lv_hi == '0 && lv_lo != FS_W'(FULL_SCALE))
                    state_next = ST_GAP;
            end
            ST_GAP:
            begin
                of_word.record_time_ms = next_reg[TIME_W-1:0];
                of_word.is_gap         = 1'b1;
                if (!gap_more)
                    state_next = ST_MEAS;
                else if (!of_full)
                    of_push = 1'b1;
            end
            ST_MEAS:
            begin
                of_word.record_time_ms = t_reg;
                of_word.level          = level_reg;
                of_word.format_changed = change_pending_reg;
                of_word.last_result    = 1'b1;
                if (!of_full)
                begin
                    of_push    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            last_time_reg      <= '0;
            change_pending_reg <= 1'b0;
            of_wr_reg          <= 1'b0;
            of_rd_reg          <= 1'b0;
            of_cnt_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_change)
            begin
                change_pending_reg <= 1'b1;
                last_time_reg      <= '0;
            end
            else if (job_take && !job_measure)
                last_time_reg <= job_time;
            else if (state_reg == ST_MEAS && !of_full)
            begin
                change_pending_reg <= 1'b0;
                last_time_reg      <= t_reg;
            end
            if (of_push)
                of_wr_reg <= ~of_wr_reg;
            if (of_pop)
                of_rd_reg <= ~of_rd_reg;
            of_cnt_reg <= of_cnt_reg + 2'(of_push) - 2'(of_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            t_reg      <= job_time;
            frames_reg <= job_frames;
            acc_reg    <= job_acc;
        end
        if (state_reg == ST_DUR && div_done)
        begin
            // a time that went backwards clears the previous time
            dur_reg     <= dur_sat;
            gap_on_reg  <= (lt_eff != '0) && (dur_sat != '0);
            next_reg    <= {1'b0, lt_eff} + (TIME_W+1)'(dur_sat);
            gap_cnt_reg <= '0;
        end
        if (state_reg == ST_ROOT && sq_done)
        begin
            level_reg <= LEVEL_MAX;
            lv_x_reg  <= LX_W'({sq_root, LEVEL_SHIFT'(0)});
            lv_q_reg  <= '0;
        end
        if (state_reg == ST_LVL)
        begin
            if (lv_hi != '0)
            begin
                lv_x_reg <= LX_W'(lv_hi) + LX_W'(lv_lo);
                lv_q_reg <= lv_q_reg + LEVEL_W'(lv_hi);
            end
            else if (lv_lo == FS_W'(FULL_SCALE))
            begin
                lv_x_reg <= '0;
                lv_q_reg <= lv_q_reg + LEVEL_W'(1);
            end
            else
                level_reg <= lv_q_reg;
        end
        if (of_push && state_reg == ST_GAP)
        begin
            next_reg    <= next_reg + (TIME_W+1)'(dur_reg);
            gap_cnt_reg <= gap_cnt_reg + GC_W'(1);
        end
        if (of_push)
            of_mem[of_wr_reg] <= of_word;
    end

    assign of_pop = pop & (of_cnt_reg != '0);
    assign empty  = of_cnt_reg == '0;
    assign record = of_mem[of_rd_reg];

endmodule
`default_nettype wire

>>> test/audio_block_rms_meter_tb.sv
// ----------------------------------------------------------------------------
// audio_block_rms_meter_tb
// Self-checking bench for the block RMS meter. It pushes audio frames through
// the frame queue and compares every record popped from the record queue
// against a predicted record list. Gap filling, saturation and format
// changes are predicted in the bench.
// ----------------------------------------------------------------------------
module audio_block_rms_meter_tb;
    import rmsm_pkg::*;

    localparam int BOUND_FRAMES = DEF_MAX_BLOCK_FRAMES;
    localparam int GAP_LIMIT    = DEF_MAX_GAPS;
    localparam int DRAIN_CYCLES = 400;
    localparam int STALL_LIMIT  = 20000;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    frame_t             frame;
    logic               empty;
    logic               pop;
    record_t            record;
    logic               wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]   wr_data;

    audio_block_rms_meter DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .frame(frame),
        .empty(empty), .pop(pop), .record(record),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    // bench copy of the meter state
    logic              mtr_enable;
    logic [RATE_W-1:0] mtr_rate;
    logic [CH_W-1:0]   mtr_chans;
    logic [47:0]       mtr_last_time;
    logic              mtr_change;
    logic [63:0]       mtr_acc;
    int unsigned       mtr_frames;

    frame_t  pending_frames[$];
    record_t expected_records[$];
    int      error_count;
    int      stall_cycles;
    int      send_gap;
    int      recv_gap;
    bit      quiet_phase;
    bit      in_taken;
    int      block_count;
    int      gap_seen;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic predict_frame(input frame_t f);
        logic [CH_W-1:0] ch;
        logic signed [15:0] smp[8];
        longint sum;
        logic [63:0] dur;
        logic [63:0] mean;
        logic [63:0] lvl;
        logic [48:0] nxt;
        int n;
        record_t r;
        ch = (mtr_chans == 0) ? 4'd1 : (mtr_chans > 8 ? 4'd8 : mtr_chans);
        smp = '{f.sample_ch0, f.sample_ch1, f.sample_ch2, f.sample_ch3,
                f.sample_ch4, f.sample_ch5, f.sample_ch6, f.sample_ch7};
        if (!mtr_enable)
        begin
            if (f.last_frame)
            begin
                mtr_last_time = f.block_time_ms;
                mtr_acc = 0;
                mtr_frames = 0;
            end
            return;
        end
        if (mtr_frames < BOUND_FRAMES)
        begin
            sum = 0;
            for (int i = 0; i < ch; i++)
                sum += smp[i];
            mtr_acc += 64'(sum * sum);
            mtr_frames++;
        end
        if (!f.last_frame)
            return;
        if (mtr_rate == 0)
            dur = 1023;
        else
        begin
            dur = 64'(mtr_frames) * 1000 / mtr_rate;
            if (dur > 1023)
                dur = 1023;
        end
        mean = (mtr_frames != 0) ? mtr_acc / mtr_frames : 0;
        lvl = int_sqrt(mean << 20) * 64 / FULL_SCALE;
        if (lvl > 64'hFFFFF)
            lvl = 64'hFFFFF;
        if (f.block_time_ms < mtr_last_time)
            mtr_last_time = 0;
        n = 0;
        if (mtr_last_time != 0 && dur != 0)
        begin
            nxt = {1'b0, mtr_last_time} + 49'(dur);
            while (nxt < {1'b0, f.block_time_ms} && n < GAP_LIMIT)
            begin
                r = '{nxt[47:0], dur[9:0], 20'd0, ch, 1'b0, 1'b1, 1'b0};
                expected_records = {expected_records, r};
                n++;
                nxt = nxt + 49'(dur);
            end
        end
        r = '{f.block_time_ms, dur[9:0], lvl[19:0], ch, mtr_change, 1'b0, 1'b1};
        expected_records = {expected_records, r};
        mtr_change = 0;
        mtr_last_time = f.block_time_ms;
        mtr_acc = 0;
        mtr_frames = 0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    // driver: hold a waiting word, otherwise idle or offer the next one; pop with random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(push && !in_taken))
            begin
                if (!quiet_phase && send_gap == 0 && $urandom_range(0, 15) == 0)
                    send_gap = $urandom_range(1, 14);
                if (send_gap > 0)
                begin
                    send_gap--;
                    push <= 1'b0;
                end
                else if (pending_frames.size() > 0)
                begin
                    push <= 1'b1;
                    frame <= pending_frames[0];
                end
                else
                    push <= 1'b0;
            end
            if (!quiet_phase && recv_gap == 0 && $urandom_range(0, 15) == 0)
                recv_gap = $urandom_range(1, 14);
            if (recv_gap > 0)
            begin
                recv_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= push && !full;
            if ((push && !full) || (pop && !empty))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (push && !full)
            begin
                predict_frame(frame);
                pending_frames.delete(0);
            end
            if (pop && !empty)
            begin
                if (record.is_gap)
                    gap_seen <= gap_seen + 1;
                if (expected_records.size() == 0)
                    report_mismatch("unexpected record", record.record_time_ms, 64'd0);
                else
                begin
                    record_t w;
                    w = expected_records[0];
                    expected_records.delete(0);
                    if (record.record_time_ms !== w.record_time_ms)
                        report_mismatch("record_time_ms", record.record_time_ms,
                                        w.record_time_ms);
                    if (record.duration_ms !== w.duration_ms)
                        report_mismatch("duration_ms", record.duration_ms, w.duration_ms);
                    if (record.level !== w.level)
                        report_mismatch("level", record.level, w.level);
                    if (record.channels_used !== w.channels_used)
                        report_mismatch("channels_used", record.channels_used,
                                        w.channels_used);
                    if (record.format_changed !== w.format_changed)
                        report_mismatch("format_changed", record.format_changed,
                                        w.format_changed);
                    if (record.is_gap !== w.is_gap)
                        report_mismatch("is_gap", record.is_gap, w.is_gap);
                    if (record.last_result !== w.last_result)
                        report_mismatch("last_result", record.last_result, w.last_result);
                end
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic frame_t make_frame(input int mode, input bit last,
                                          input logic [47:0] t);
        frame_t f;
        logic [15:0] s[8];
        for (int i = 0; i < 8; i++)
        begin
            case (mode)
                0: s[i] = 16'h7FFF;
                1: s[i] = 16'h8000;
                2: s[i] = 16'h0000;
                default: s[i] = 16'($urandom);
            endcase
        end
        f = '{s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7], last, t};
        return f;
    endfunction

    task automatic wait_idle();
        while (pending_frames.size() > 0 || push || expected_records.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_ENABLE: mtr_enable = val[0];
            REG_SAMPLE_RATE:
            begin
                if (val != mtr_rate)
                begin
                    mtr_change = 1;
                    mtr_last_time = 0;
                end
                mtr_rate = val;
            end
            default:
            begin
                if (val[CH_W-1:0] != mtr_chans)
                begin
                    mtr_change = 1;
                    mtr_last_time = 0;
                end
                mtr_chans = val[CH_W-1:0];
            end
        endcase
    endtask

    // queue one block of n frames ending at time t
    task automatic queue_block(input int n, input int mode, input logic [47:0] t);
        for (int i = 0; i < n; i++)
            pending_frames = {pending_frames, make_frame(mode, i == n - 1, t)};
        block_count++;
    endtask

    initial
    begin
        logic [47:0] clock_ms;
        int n;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        frame = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        error_count = 0;
        stall_cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        quiet_phase = 0;
        in_taken = 0;
        block_count = 0;
        gap_seen = 0;
        mtr_enable = ENABLE_RST;
        mtr_rate = RATE_RST;
        mtr_chans = CHAN_RST;
        mtr_last_time = 0;
        mtr_change = 0;
        mtr_acc = 0;
        mtr_frames = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // disabled: only time tracking
        queue_block(2, 3, 48'd100);
        wait_idle();
        write_reg(REG_ENABLE, 18'd1);
        write_reg(REG_CHANNEL_COUNT, 18'd8);
        write_reg(REG_SAMPLE_RATE, 18'd8000);
        queue_block(3, 0, 48'd10);
        queue_block(3, 1, 48'd12);
        queue_block(2, 2, 48'd5);
        queue_block(8, 3, 48'd100);
        queue_block(1, 0, 48'hFFFF_FFFF_FFFF);
        queue_block(1, 3, 48'd0);
        queue_block(8, 1, 48'd200);
        wait_idle();
        // out of range channel counts, zero rate
        write_reg(REG_CHANNEL_COUNT, 18'd0);
        write_reg(REG_SAMPLE_RATE, 18'd0);
        queue_block(2, 3, 48'd50);
        queue_block(1, 3, 48'd60000);
        wait_idle();
        write_reg(REG_CHANNEL_COUNT, 18'd15);
        write_reg(REG_SAMPLE_RATE, 18'd192000);
        queue_block(3, 0, 48'd7);
        wait_idle();
        write_reg(REG_SAMPLE_RATE, 18'h3FFFF);
        queue_block(2, 3, 48'd9);
        wait_idle();

        // random phases with various settings
        clock_ms = 48'd1000;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_SAMPLE_RATE, ph == 0 ? 18'd8000 :
                      (ph == 5 ? 18'd192000 : 18'($urandom_range(8000, 192000))));
            write_reg(REG_CHANNEL_COUNT, 18'($urandom_range(1, 8)));
            write_reg(REG_ENABLE, (ph == 3) ? 18'd0 : 18'd1);
            if (ph == 5)
                quiet_phase = 1;
            for (int b = 0; b < 10; b++)
            begin
                n = $urandom_range(1, 6);
                case ($urandom_range(0, 5))
                    0: clock_ms = clock_ms + 48'($urandom_range(0, 2000));
                    1: clock_ms = 48'($urandom);
                    2: clock_ms = {16'($urandom), 32'($urandom)};
                    default: clock_ms = clock_ms + 48'($urandom_range(0, 3));
                endcase
                queue_block(n, $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : 3,
                            clock_ms);
            end
            wait_idle();
        end

        $display("Covered %0d blocks, %0d gap records, enable off and on,",
                 block_count, gap_seen);
        $display("channel counts 0..15, rates from zero to the register maximum.");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> audio_block_rms_meter.f
hw/rtl/rmsm_pkg.sv
hw/rtl/rmsm_div.sv
hw/rtl/rmsm_sqrt.sv
hw/rtl/rmsm_front.sv
hw/rtl/rmsm_back.sv
hw/rtl/audio_block_rms_meter.sv
test/audio_block_rms_meter_tb.sv
